### rtl/i2cm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_pkg: shared types and constants of the I2C master byte engine
// Controller state, phase codes, command codes and the result word.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam int DIVIDER_WIDTH = 16;
    localparam int TRIES_W       = 3;
    localparam int BYTE_W        = 8;
    localparam int BITS_W        = 4;

    localparam logic [BITS_W-1:0] ACK_BIT = 4'd8;

    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_START = 3'd1,
        OP_WRITE = 3'd2,
        OP_RETRY = 3'd3,
        OP_READ  = 3'd4,
        OP_STOP  = 3'd5
    } t_op;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_START = 5'b00010,
        ST_WRITE = 5'b00100,
        ST_READ  = 5'b01000,
        ST_STOP  = 5'b10000
    } t_ctrl;

    typedef enum logic [0:0] {
        CFG_QUARTER = 1'b0,
        CFG_TRIES   = 1'b1
    } t_cfg_idx;

    localparam logic [1:0] PH_LOW    = 2'd0;
    localparam logic [1:0] PH_RISE   = 2'd1;
    localparam logic [1:0] PH_HIGH   = 2'd2;
    localparam logic [1:0] PH_FALL   = 2'd3;

    typedef struct packed {
        t_ctrl                     ctrl;
        logic [1:0]                phase;
        logic [DIVIDER_WIDTH-1:0]  tick;
        logic [BITS_W-1:0]         bits;
        logic [BYTE_W-1:0]         shift;
        logic [TRIES_W-1:0]        tries;
        logic                      scl;
        logic                      sda;
        logic                      ack;
        logic [BYTE_W-1:0]         rx;
    } t_state;

    typedef struct packed {
        logic              scl_release;
        logic              sda_release;
        logic              busy_res;
        logic              done_res;
        logic              acked;
        logic [BYTE_W-1:0] read_data;
    } t_result;

endpackage

### rtl/i2cm_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_in_if: tick channel into the I2C master
// Carries one tick word: command, data byte and sampled bus pins.
// ----------------------------------------------------------------------------
interface i2cm_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [7:0] write_data;
    logic       master_ack;
    logic       scl_in;
    logic       sda_in;

    modport source (output valid, output opcode, output write_data, output master_ack,
                    output scl_in, output sda_in, input ready);
    modport sink   (input valid, input opcode, input write_data, input master_ack,
                    input scl_in, input sda_in, output ready);
endinterface

### rtl/i2cm_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_out_if: result channel out of the I2C master
// Carries one result word per tick: pin releases and status.
// ----------------------------------------------------------------------------
interface i2cm_out_if;
    logic       valid;
    logic       ready;
    logic       scl_release;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic       acked;
    logic [7:0] read_data;

    modport source (output valid, output scl_release, output sda_release, output busy_res,
                    output done_res, output acked, output read_data, input ready);
    modport sink   (input valid, input scl_release, input sda_release, input busy_res,
                    input done_res, input acked, input read_data, output ready);
endinterface

### rtl/i2cm_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_step: next-state logic of the I2C master
// Computes the controller state and result word that follow one tick.
// ----------------------------------------------------------------------------
module i2cm_step (
    input  i2cm_pkg::t_state                        i_st,
    input  logic [2:0]                              i_opcode,
    input  logic [7:0]                              i_write_data,
    input  logic                                    i_master_ack,
    input  logic                                    i_scl_in,
    input  logic                                    i_sda_in,
    input  logic [i2cm_pkg::DIVIDER_WIDTH-1:0]      i_quarter,
    input  logic [i2cm_pkg::TRIES_W-1:0]            i_max_tries,
    output i2cm_pkg::t_state                        o_st,
    output i2cm_pkg::t_result                       o_res
);

    function automatic i2cm_pkg::t_state enter_phase(input i2cm_pkg::t_state s,
                                                     input logic [1:0] p);
        i2cm_pkg::t_state r;
        r       = s;
        r.phase = p;
        r.tick  = '0;
        unique case (s.ctrl)
            i2cm_pkg::ST_START: begin
                unique case (p)
                    i2cm_pkg::PH_LOW:  r.sda = 1'b1;
                    i2cm_pkg::PH_RISE: r.scl = 1'b1;
                    i2cm_pkg::PH_HIGH: r.sda = 1'b0;
                    default:           r.scl = 1'b0;
                endcase
            end
            i2cm_pkg::ST_STOP: begin
                unique case (p)
                    i2cm_pkg::PH_LOW: begin
                        r.scl = 1'b0;
                        r.sda = 1'b0;
                    end
                    i2cm_pkg::PH_RISE: r.scl = 1'b1;
                    i2cm_pkg::PH_HIGH: r.sda = 1'b1;
                    default:           r.scl = s.scl;
                endcase
            end
            i2cm_pkg::ST_WRITE, i2cm_pkg::ST_READ: begin
                unique case (p)
                    i2cm_pkg::PH_LOW: begin
                        r.scl = 1'b0;
                        if (s.bits >= i2cm_pkg::ACK_BIT) begin
                            r.sda = (s.ctrl == i2cm_pkg::ST_READ) ? ~s.tries[0] : 1'b1;
                        end else if (s.ctrl == i2cm_pkg::ST_WRITE) begin
                            r.sda = s.shift[7];
                        end else begin
                            r.sda = 1'b1;
                        end
                    end
                    i2cm_pkg::PH_RISE: r.scl = 1'b1;
                    i2cm_pkg::PH_HIGH: r.scl = s.scl;
                    default:           r.scl = 1'b0;
                endcase
            end
            default: r.phase = p;
        endcase
        return r;
    endfunction

    i2cm_pkg::t_state                       n_st;
    logic                                   n_done;
    logic                                   fin;
    logic [i2cm_pkg::DIVIDER_WIDTH:0]       tick_inc;
    logic [i2cm_pkg::DIVIDER_WIDTH:0]       q;

    always_comb begin
        n_st     = i_st;
        n_done   = 1'b0;
        fin      = 1'b0;
        tick_inc = {1'b0, i_st.tick} + 1'b1;
        q        = (i_quarter == '0) ? {{i2cm_pkg::DIVIDER_WIDTH{1'b0}}, 1'b1}
                                     : {1'b0, i_quarter};
        if (i_st.ctrl == i2cm_pkg::ST_IDLE) begin
            if (i_opcode != i2cm_pkg::OP_NONE && i_opcode <= i2cm_pkg::OP_STOP) begin
                n_st.bits = '0;
                unique case (i2cm_pkg::t_op'(i_opcode))
                    i2cm_pkg::OP_START: n_st.ctrl = i2cm_pkg::ST_START;
                    i2cm_pkg::OP_WRITE: begin
                        n_st.ctrl  = i2cm_pkg::ST_WRITE;
                        n_st.shift = i_write_data;
                        n_st.tries = 3'd1;
                    end
                    i2cm_pkg::OP_RETRY: begin
                        n_st.ctrl  = i2cm_pkg::ST_WRITE;
                        n_st.shift = i_write_data;
                        n_st.tries = (i_max_tries == '0) ? 3'd1 : i_max_tries;
                    end
                    i2cm_pkg::OP_READ: begin
                        n_st.ctrl  = i2cm_pkg::ST_READ;
                        n_st.shift = '0;
                        n_st.tries = {2'b00, i_master_ack};
                    end
                    default: n_st.ctrl = i2cm_pkg::ST_STOP;
                endcase
                n_st = enter_phase(n_st, i2cm_pkg::PH_LOW);
            end
        end else if (!(i_st.phase == i2cm_pkg::PH_RISE && !i_scl_in)) begin
            if (tick_inc >= q) begin
                if (i_st.ctrl == i2cm_pkg::ST_START || i_st.ctrl == i2cm_pkg::ST_STOP) begin
                    fin = (i_st.phase == i2cm_pkg::PH_FALL);
                end else if (i_st.phase == i2cm_pkg::PH_HIGH) begin
                    if (i_st.bits < i2cm_pkg::ACK_BIT) begin
                        if (i_st.ctrl == i2cm_pkg::ST_READ) begin
                            n_st.shift = {i_st.shift[6:0], i_sda_in};
                        end
                    end else if (i_st.ctrl == i2cm_pkg::ST_WRITE) begin
                        n_st.ack = ~i_sda_in;
                    end
                end else if (i_st.phase == i2cm_pkg::PH_FALL) begin
                    if (i_st.bits < i2cm_pkg::ACK_BIT) begin
                        if (i_st.ctrl == i2cm_pkg::ST_WRITE) begin
                            n_st.shift = {i_st.shift[6:0], i_st.shift[7]};
                        end
                        n_st.bits = i_st.bits + 1'b1;
                    end else if (i_st.ctrl == i2cm_pkg::ST_READ) begin
                        n_st.rx = i_st.shift;
                        fin     = 1'b1;
                    end else if (i_st.ack || i_st.tries <= 3'd1) begin
                        fin = 1'b1;
                    end else begin
                        n_st.tries = i_st.tries - 1'b1;
                        n_st.bits  = '0;
                    end
                end
                if (fin) begin
                    n_st.ctrl  = i2cm_pkg::ST_IDLE;
                    n_st.phase = i2cm_pkg::PH_LOW;
                    n_st.tick  = '0;
                    n_done     = 1'b1;
                end else begin
                    n_st = enter_phase(n_st, i_st.phase + 1'b1);
                end
            end else begin
                n_st.tick = tick_inc[i2cm_pkg::DIVIDER_WIDTH-1:0];
            end
        end
    end

    assign o_st                = n_st;
    assign o_res.scl_release   = n_st.scl;
    assign o_res.sda_release   = n_st.sda;
    assign o_res.busy_res      = (n_st.ctrl != i2cm_pkg::ST_IDLE);
    assign o_res.done_res      = n_done;
    assign o_res.acked         = n_st.ack;
    assign o_res.read_data     = n_st.rx;

endmodule

### rtl/i2c_master_byte_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_byte_engine: tick-driven I2C master byte engine
// Runs start, write, retried write, read and stop over open-drain pins.
// ----------------------------------------------------------------------------
//  Channel   Direction  Word
//  i_word    in         opcode, write_data, master_ack, scl_in, sda_in
//  o_word    out        scl_release, sda_release, busy_res, done_res, acked,
//                       read_data
//  i_cfg_*   in         quarter_period (index 0), max_tries (index 1)
//
// Every accepted word advances the controller by one tick and yields one
// result word on the next cycle; one word per cycle is sustained.
// The result register is the only stage, so input is taken whenever it is
// empty or being emptied. A stalled output stalls the input.
// Synchronous reset returns the bus to released and the controller to idle.
module i2c_master_byte_engine (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    i2cm_in_if.sink                                   i_word,
    i2cm_out_if.source                                o_word,
    input  logic                                      i_cfg_we,
    input  logic [0:0]                                i_cfg_idx,
    input  logic [i2cm_pkg::DIVIDER_WIDTH-1:0]        i_cfg_data
);

    i2cm_pkg::t_state                       r_st;
    i2cm_pkg::t_state                       n_st;
    i2cm_pkg::t_result                      r_res;
    i2cm_pkg::t_result                      n_res;
    logic                                   r_out_valid;
    logic [i2cm_pkg::DIVIDER_WIDTH-1:0]     r_quarter;
    logic [i2cm_pkg::TRIES_W-1:0]           r_max_tries;
    logic                                   accept;

    assign i_word.ready = !r_out_valid || o_word.ready;
    assign accept       = i_word.valid && i_word.ready;

    i2cm_step u_step (
        .i_st         (r_st),
        .i_opcode     (i_word.opcode),
        .i_write_data (i_word.write_data),
        .i_master_ack (i_word.master_ack),
        .i_scl_in     (i_word.scl_in),
        .i_sda_in     (i_word.sda_in),
        .i_quarter    (r_quarter),
        .i_max_tries  (r_max_tries),
        .o_st         (n_st),
        .o_res        (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quarter   <= 16'd63;
            r_max_tries <= 3'd3;
        end else if (i_cfg_we) begin
            unique case (i2cm_pkg::t_cfg_idx'(i_cfg_idx))
                i2cm_pkg::CFG_QUARTER: r_quarter   <= i_cfg_data;
                default:               r_max_tries <= i_cfg_data[i2cm_pkg::TRIES_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.ctrl   <= i2cm_pkg::ST_IDLE;
            r_st.phase  <= i2cm_pkg::PH_LOW;
            r_st.tick   <= '0;
            r_st.bits   <= '0;
            r_st.shift  <= '0;
            r_st.tries  <= '0;
            r_st.scl    <= 1'b1;
            r_st.sda    <= 1'b1;
            r_st.ack    <= 1'b0;
            r_st.rx     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_st        <= n_st;
                r_out_valid <= 1'b1;
            end else if (o_word.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= n_res;
        end
    end

    assign o_word.valid       = r_out_valid;
    assign o_word.scl_release = r_res.scl_release;
    assign o_word.sda_release = r_res.sda_release;
    assign o_word.busy_res    = r_res.busy_res;
    assign o_word.done_res    = r_res.done_res;
    assign o_word.acked       = r_res.acked;
    assign o_word.read_data   = r_res.read_data;

    a_word_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_word.valid)
        else $error("accepted word produced no result");

    a_done_is_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_word.valid && o_word.done_res) |-> (!o_word.busy_res && r_st.ctrl == i2cm_pkg::ST_IDLE))
        else $error("done reported while controller busy");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.ctrl == i2cm_pkg::ST_IDLE) |-> (r_st.tick == '0 && r_st.phase == i2cm_pkg::PH_LOW))
        else $error("idle controller holds phase or tick count");

    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.bits <= i2cm_pkg::ACK_BIT)
        else $error("bit counter past acknowledge bit");

    a_stall_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> $stable(r_st))
        else $error("controller moved without an accepted word");

endmodule

### test/i2cm_bus_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_bus_checker: pin and status checker for the I2C master byte engine
// Watches the tick, result and register ports and keeps its own model of
// the bit sequencer. Each accepted tick word yields one predicted pin and
// status word, which is compared field by field with the result word the
// block delivers.
// ----------------------------------------------------------------------------
module i2cm_bus_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    i2cm_in_if                                 i_tick,
    i2cm_out_if                                i_res,
    input  logic                               i_cfg_we,
    input  logic [0:0]                         i_cfg_idx,
    input  logic [i2cm_pkg::DIVIDER_WIDTH-1:0] i_cfg_data,
    output int                                 o_fail_count,
    output int                                 o_pending,
    output logic                               o_busy
);

    logic [i2cm_pkg::DIVIDER_WIDTH-1:0] qtr_cfg;
    logic [i2cm_pkg::TRIES_W-1:0]       tries_cfg;

    i2cm_pkg::t_ctrl                    ctl;
    logic [1:0]                         ph;
    logic [i2cm_pkg::DIVIDER_WIDTH-1:0] tick_cnt;
    logic [i2cm_pkg::BITS_W-1:0]        bit_cnt;
    logic [i2cm_pkg::BYTE_W-1:0]        shreg;
    logic [i2cm_pkg::TRIES_W-1:0]       tries;
    logic                               scl_drv;
    logic                               sda_drv;
    logic                               ack_flag;
    logic [i2cm_pkg::BYTE_W-1:0]        rx_byte;

    i2cm_pkg::t_result pin_status_q[$];
    i2cm_pkg::t_result got;
    i2cm_pkg::t_result want;

    function automatic void drive_phase(input logic [1:0] p);
        ph       = p;
        tick_cnt = '0;
        case (ctl)
            i2cm_pkg::ST_START: begin
                case (p)
                    i2cm_pkg::PH_LOW:  sda_drv = 1'b1;
                    i2cm_pkg::PH_RISE: scl_drv = 1'b1;
                    i2cm_pkg::PH_HIGH: sda_drv = 1'b0;
                    default:           scl_drv = 1'b0;
                endcase
            end
            i2cm_pkg::ST_STOP: begin
                case (p)
                    i2cm_pkg::PH_LOW: begin
                        scl_drv = 1'b0;
                        sda_drv = 1'b0;
                    end
                    i2cm_pkg::PH_RISE: scl_drv = 1'b1;
                    i2cm_pkg::PH_HIGH: sda_drv = 1'b1;
                    default: ;
                endcase
            end
            i2cm_pkg::ST_WRITE, i2cm_pkg::ST_READ: begin
                case (p)
                    i2cm_pkg::PH_LOW: begin
                        scl_drv = 1'b0;
                        if (bit_cnt >= i2cm_pkg::ACK_BIT) begin
                            sda_drv = (ctl == i2cm_pkg::ST_READ) ? ~tries[0] : 1'b1;
                        end else if (ctl == i2cm_pkg::ST_WRITE) begin
                            sda_drv = shreg[i2cm_pkg::BYTE_W-1];
                        end else begin
                            sda_drv = 1'b1;
                        end
                    end
                    i2cm_pkg::PH_RISE: scl_drv = 1'b1;
                    i2cm_pkg::PH_FALL: scl_drv = 1'b0;
                    default: ;
                endcase
            end
            default: ;
        endcase
    endfunction

    // Returns 1 when the phase that just ran out finishes the command.
    function automatic bit close_phase(input logic sda);
        if (ctl == i2cm_pkg::ST_START || ctl == i2cm_pkg::ST_STOP) begin
            return ph == i2cm_pkg::PH_FALL;
        end
        if (ph == i2cm_pkg::PH_HIGH) begin
            if (bit_cnt < i2cm_pkg::ACK_BIT) begin
                if (ctl == i2cm_pkg::ST_READ) begin
                    shreg = {shreg[i2cm_pkg::BYTE_W-2:0], sda};
                end
            end else if (ctl == i2cm_pkg::ST_WRITE) begin
                ack_flag = ~sda;
            end
            return 1'b0;
        end
        if (ph != i2cm_pkg::PH_FALL) begin
            return 1'b0;
        end
        if (bit_cnt < i2cm_pkg::ACK_BIT) begin
            if (ctl == i2cm_pkg::ST_WRITE) begin
                shreg = {shreg[i2cm_pkg::BYTE_W-2:0], shreg[i2cm_pkg::BYTE_W-1]};
            end
            bit_cnt++;
            return 1'b0;
        end
        if (ctl == i2cm_pkg::ST_READ) begin
            rx_byte = shreg;
            return 1'b1;
        end
        if (ack_flag || tries <= 3'd1) begin
            return 1'b1;
        end
        tries--;
        bit_cnt = '0;
        return 1'b0;
    endfunction

    function automatic i2cm_pkg::t_result next_pin_status(input logic [2:0] op,
                                                          input logic [7:0] data,
                                                          input logic mack,
                                                          input logic scl,
                                                          input logic sda);
        i2cm_pkg::t_result                r;
        logic [i2cm_pkg::DIVIDER_WIDTH:0] q;
        logic                             fin;
        fin = 1'b0;
        if (ctl == i2cm_pkg::ST_IDLE) begin
            if (op >= i2cm_pkg::OP_START && op <= i2cm_pkg::OP_STOP) begin
                bit_cnt = '0;
                case (op)
                    i2cm_pkg::OP_START: ctl = i2cm_pkg::ST_START;
                    i2cm_pkg::OP_WRITE, i2cm_pkg::OP_RETRY: begin
                        ctl   = i2cm_pkg::ST_WRITE;
                        shreg = data;
                        if (op == i2cm_pkg::OP_RETRY) begin
                            tries = (tries_cfg == '0) ? 3'd1 : tries_cfg;
                        end else begin
                            tries = 3'd1;
                        end
                    end
                    i2cm_pkg::OP_READ: begin
                        ctl   = i2cm_pkg::ST_READ;
                        shreg = '0;
                        tries = {2'b00, mack};
                    end
                    default: ctl = i2cm_pkg::ST_STOP;
                endcase
                drive_phase(i2cm_pkg::PH_LOW);
            end
        end else begin
            q = (qtr_cfg == '0) ? {{i2cm_pkg::DIVIDER_WIDTH{1'b0}}, 1'b1} : {1'b0, qtr_cfg};
            if (!(ph == i2cm_pkg::PH_RISE && !scl)) begin
                tick_cnt++;
                if ({1'b0, tick_cnt} >= q) begin
                    if (close_phase(sda)) begin
                        ctl      = i2cm_pkg::ST_IDLE;
                        ph       = i2cm_pkg::PH_LOW;
                        tick_cnt = '0;
                        fin      = 1'b1;
                    end else begin
                        drive_phase(ph + 2'd1);
                    end
                end
            end
        end
        r.scl_release = scl_drv;
        r.sda_release = sda_drv;
        r.busy_res    = (ctl != i2cm_pkg::ST_IDLE);
        r.done_res    = fin;
        r.acked       = ack_flag;
        r.read_data   = rx_byte;
        return r;
    endfunction

    function automatic void check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            o_fail_count++;
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            qtr_cfg      = 16'd63;
            tries_cfg    = 3'd3;
            ctl          = i2cm_pkg::ST_IDLE;
            ph           = i2cm_pkg::PH_LOW;
            tick_cnt     = '0;
            bit_cnt      = '0;
            shreg        = '0;
            tries        = '0;
            scl_drv      = 1'b1;
            sda_drv      = 1'b1;
            ack_flag     = 1'b0;
            rx_byte      = '0;
            o_fail_count = 0;
            pin_status_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == i2cm_pkg::CFG_QUARTER) begin
                    qtr_cfg = i_cfg_data;
                end else begin
                    tries_cfg = i_cfg_data[i2cm_pkg::TRIES_W-1:0];
                end
            end
            if (i_res.valid && i_res.ready) begin
                got = {i_res.scl_release, i_res.sda_release, i_res.busy_res,
                       i_res.done_res, i_res.acked, i_res.read_data};
                if (pin_status_q.size() == 0) begin
                    o_fail_count++;
                    $display("%0t ns: unexpected result word, expected none, got %0h",
                             $time, got);
                end else begin
                    want = pin_status_q.pop_front();
                    check_field("scl_release", int'(want.scl_release), int'(got.scl_release));
                    check_field("sda_release", int'(want.sda_release), int'(got.sda_release));
                    check_field("busy_res", int'(want.busy_res), int'(got.busy_res));
                    check_field("done_res", int'(want.done_res), int'(got.done_res));
                    check_field("acked", int'(want.acked), int'(got.acked));
                    check_field("read_data", int'(want.read_data), int'(got.read_data));
                end
            end
            if (i_tick.valid && i_tick.ready) begin
                pin_status_q.push_back(next_pin_status(i_tick.opcode, i_tick.write_data,
                                                       i_tick.master_ack, i_tick.scl_in,
                                                       i_tick.sda_in));
            end
        end
        o_pending = pin_status_q.size();
        o_busy    = (ctl != i2cm_pkg::ST_IDLE);
    end

endmodule

### test/tb_i2c_master_byte_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i2c_master_byte_engine: testbench of the I2C master byte engine
// Feeds tick words that carry commands and sampled bus levels: directed
// start, write, retried write, read and stop commands at the register
// extremes, then random I2C transactions under changing settings, and a
// final start condition at the longest quarter period. Both channels idle
// at random; the checker beside the block predicts every result word.
// ----------------------------------------------------------------------------
module tb_i2c_master_byte_engine;

    localparam logic [2:0] OP_UNUSED_LO = 3'd6;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;
    localparam int RANDOM_TICKS = 200;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 200;
    localparam int STALL_LIMIT  = 2000;

    typedef logic [i2cm_pkg::DIVIDER_WIDTH-1:0] t_cfg_word;

    typedef enum int {
        SDA_RANDOM,
        SDA_LOW,
        SDA_HIGH
    } t_sda_mode;

    logic       i_clk;
    logic       i_rst_n;
    logic       cfg_we;
    logic [0:0] cfg_idx;
    t_cfg_word  cfg_data;
    int         fail_count;
    int         pending;
    logic       model_busy;
    bit         pacing_on;
    int         busy_ticks;
    int         stall_cycles;

    i2cm_in_if  tick_ch ();
    i2cm_out_if res_ch ();

    i2c_master_byte_engine i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_word     (tick_ch),
        .o_word     (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    i2cm_bus_checker u_bus_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (tick_ch),
        .i_res        (res_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_busy       (model_busy)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Starts and ends at a falling edge; the word stays offered until taken.
    task automatic send_tick(input logic [2:0] op, input logic [7:0] data, input logic mack,
                             input logic scl, input logic sda);
        int gap;
        gap = pacing_on ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        tick_ch.valid      <= 1'b1;
        tick_ch.opcode     <= op;
        tick_ch.write_data <= data;
        tick_ch.master_ack <= mack;
        tick_ch.scl_in     <= scl;
        tick_ch.sda_in     <= sda;
        do @(posedge i_clk); while (!tick_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic run_command(input logic [2:0] op, input logic [7:0] data,
                               input logic mack, input t_sda_mode mode);
        logic [2:0] noise_op;
        logic       sda;
        send_tick(op, data, mack, 1'b1, 1'($urandom_range(0, 1)));
        while (model_busy) begin
            noise_op = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7))
                                                   : i2cm_pkg::OP_NONE;
            case (mode)
                SDA_LOW:  sda = 1'b0;
                SDA_HIGH: sda = 1'b1;
                default:  sda = 1'($urandom_range(0, 1));
            endcase
            send_tick(noise_op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      $urandom_range(0, 5) != 0, sda);
            busy_ticks++;
        end
    endtask

    task automatic write_reg(input i2cm_pkg::t_cfg_idx idx, input t_cfg_word val);
        tick_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_transaction();
        t_sda_mode addr_mode;
        logic [2:0] idle_op;
        addr_mode = ($urandom_range(0, 4) < 3) ? SDA_LOW : t_sda_mode'($urandom_range(0, 2));
        run_command(i2cm_pkg::OP_START, 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)), SDA_RANDOM);
        run_command(($urandom_range(0, 3) == 0) ? i2cm_pkg::OP_WRITE : i2cm_pkg::OP_RETRY,
                    8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), addr_mode);
        repeat ($urandom_range(0, 3)) begin
            run_command(($urandom_range(0, 1) == 0) ? i2cm_pkg::OP_WRITE : i2cm_pkg::OP_READ,
                        8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                        t_sda_mode'($urandom_range(0, 2)));
        end
        if ($urandom_range(0, 3) == 0) begin
            run_command(i2cm_pkg::OP_START, 8'($urandom_range(0, 255)), 1'b0, SDA_RANDOM);
            run_command(i2cm_pkg::OP_READ, 8'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1)), SDA_RANDOM);
        end
        if ($urandom_range(0, 7) != 0) begin
            run_command(i2cm_pkg::OP_STOP, 8'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1)), SDA_RANDOM);
        end
        repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(0, 2))
                0:       idle_op = i2cm_pkg::OP_NONE;
                1:       idle_op = OP_UNUSED_LO;
                default: idle_op = OP_UNUSED_HI;
            endcase
            send_tick(idle_op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        int n_words;
        int gap;
        n_words      = 0;
        res_ch.ready = 1'b0;
        forever begin
            gap = pacing_on ? $urandom_range(0, 7) : 0;
            if (n_words == HOLD_AT) begin
                gap = HOLD_CYCLES;
            end
            @(negedge i_clk);
            if (gap > 0) begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
            n_words++;
        end
    end

    always @(posedge i_clk) begin
        if ((tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("** i2c_master_byte_engine: FAILED **");
            $finish;
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = i2cm_pkg::CFG_QUARTER;
        cfg_data           = '0;
        tick_ch.valid      = 1'b0;
        tick_ch.opcode     = i2cm_pkg::OP_NONE;
        tick_ch.write_data = '0;
        tick_ch.master_ack = 1'b0;
        tick_ch.scl_in     = 1'b1;
        tick_ch.sda_in     = 1'b1;
        pacing_on          = 1'b1;
        busy_ticks         = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Settings after reset, then a zero quarter period and zero tries.
        run_command(i2cm_pkg::OP_START, 8'h00, 1'b0, SDA_RANDOM);
        write_reg(i2cm_pkg::CFG_QUARTER, 16'd0);
        write_reg(i2cm_pkg::CFG_TRIES, 16'd0);
        send_tick(i2cm_pkg::OP_NONE, 8'hFF, 1'b1, 1'b0, 1'b0);
        send_tick(OP_UNUSED_LO, 8'h00, 1'b0, 1'b1, 1'b1);
        send_tick(OP_UNUSED_HI, 8'hA5, 1'b1, 1'b1, 1'b0);
        run_command(i2cm_pkg::OP_START, 8'h00, 1'b0, SDA_RANDOM);
        run_command(i2cm_pkg::OP_RETRY, 8'hFF, 1'b0, SDA_HIGH);
        run_command(i2cm_pkg::OP_WRITE, 8'h00, 1'b1, SDA_LOW);
        run_command(i2cm_pkg::OP_READ, 8'h00, 1'b1, SDA_RANDOM);
        run_command(i2cm_pkg::OP_READ, 8'hFF, 1'b0, SDA_HIGH);
        run_command(i2cm_pkg::OP_READ, 8'h00, 1'b1, SDA_LOW);
        run_command(i2cm_pkg::OP_START, 8'h00, 1'b0, SDA_RANDOM);
        run_command(i2cm_pkg::OP_STOP, 8'h00, 1'b0, SDA_RANDOM);

        write_reg(i2cm_pkg::CFG_QUARTER, 16'd1);
        write_reg(i2cm_pkg::CFG_TRIES, 16'd7);
        run_command(i2cm_pkg::OP_START, 8'h00, 1'b0, SDA_RANDOM);
        run_command(i2cm_pkg::OP_RETRY, 8'hA5, 1'b0, SDA_HIGH);
        run_command(i2cm_pkg::OP_RETRY, 8'h5A, 1'b0, SDA_RANDOM);
        run_command(i2cm_pkg::OP_STOP, 8'h00, 1'b0, SDA_RANDOM);
        write_reg(i2cm_pkg::CFG_QUARTER, 16'd2);
        write_reg(i2cm_pkg::CFG_TRIES, 16'd1);
        run_command(i2cm_pkg::OP_RETRY, 8'h3C, 1'b1, SDA_HIGH);

        busy_ticks = 0;
        while (busy_ticks < RANDOM_TICKS) begin
            write_reg(i2cm_pkg::CFG_QUARTER,
                      ($urandom_range(0, 9) == 0) ? t_cfg_word'($urandom_range(0, 4))
                                                  : t_cfg_word'($urandom_range(1, 2)));
            write_reg(i2cm_pkg::CFG_TRIES, t_cfg_word'($urandom_range(0, 7)));
            pacing_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(1, 2)) run_transaction();
        end

        // Longest quarter period, run back to back for the first ticks of a start.
        pacing_on = 1'b0;
        write_reg(i2cm_pkg::CFG_QUARTER, 16'hFFFF);
        send_tick(i2cm_pkg::OP_START, 8'h00, 1'b0, 1'b1, 1'b1);
        repeat (16) send_tick(i2cm_pkg::OP_NONE, 8'h00, 1'b0, 1'b1, 1'b1);

        tick_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("** i2c_master_byte_engine: PASSED **");
        end else begin
            $display("** i2c_master_byte_engine: FAILED **");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/i2cm_pkg.sv
rtl/i2cm_in_if.sv
rtl/i2cm_out_if.sv
rtl/i2cm_step.sv
rtl/i2c_master_byte_engine.sv
test/i2cm_bus_checker.sv
test/tb_i2c_master_byte_engine.sv
